// ===== sv/swm_pkg.sv =====
// shared types and constants for the sliding window maximum block
package swm_pkg;

  localparam int SAMPLE_BITS         = 16;
  localparam int WIN_CFG_BITS        = 11;
  localparam int DEF_WINDOW_CAPACITY = 1024;
  localparam logic [WIN_CFG_BITS-1:0] WINDOW_SIZE_RESET = WIN_CFG_BITS'(1);

  typedef struct packed {
    logic                          last_sample;
    logic signed [SAMPLE_BITS-1:0] sample;
  } swm_in_t;

  typedef struct packed {
    logic                          last_result;
    logic signed [SAMPLE_BITS-1:0] window_max;
  } swm_out_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic     load;
    swm_out_t data;
  } swm_res_t;

endpackage

// ===== sv/swm_out_reg.sv =====
// output register that holds a finished result until its transfer completes
module swm_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  swm_pkg::swm_res_t res,
  output logic              blocked,
  output logic              out_valid,
  input  logic              out_stall,
  output swm_pkg::swm_out_t out_data
);
  import swm_pkg::*;

  logic     out_valid_r;
  logic     out_valid_nxt;
  swm_out_t out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_data_r <= res.data;
    end
  end

  assign blocked   = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/swm_seq.sv =====
// deque sequencer: entry memory, pointers and the per-sample read-modify-write steps
module swm_seq #(
  parameter int unsigned WINDOW_CAPACITY = swm_pkg::DEF_WINDOW_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [swm_pkg::WIN_CFG_BITS-1:0]    window_size,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  swm_pkg::swm_in_t                    in_data,
  input  logic                                blocked,
  output swm_pkg::swm_res_t                   res
);
  import swm_pkg::*;

  localparam int AW = (WINDOW_CAPACITY > 1) ? $clog2(WINDOW_CAPACITY) : 1;
  localparam int PW = $clog2(2 * WINDOW_CAPACITY);
  localparam int OW = $clog2(WINDOW_CAPACITY + 1);
  localparam int EW = SAMPLE_BITS + PW;
  localparam int KW = WIN_CFG_BITS;
  localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_CAPACITY - 1);
  localparam logic [PW-1:0] POS_LAST = PW'(2 * WINDOW_CAPACITY - 1);
  localparam logic [OW-1:0] OCC_FULL = OW'(WINDOW_CAPACITY);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HEAD   = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? PTR_LAST : p - AW'(1);
  endfunction

  logic [EW-1:0] mem [WINDOW_CAPACITY];
  logic [EW-1:0] rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [EW-1:0] wr_data;

  logic [2:0]                    state_r, state_nxt;
  logic [AW-1:0]                 head_r, head_nxt;
  logic [AW-1:0]                 tail_r, tail_nxt;
  logic [OW-1:0]                 occ_r, occ_nxt;
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic [KW-1:0]                 seen_r, seen_nxt;
  logic [KW-1:0]                 k_r, k_nxt;
  logic signed [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic                          last_r, last_nxt;
  logic                          fwd_r, fwd_nxt;

  logic signed [SAMPLE_BITS-1:0] rd_val;
  logic [PW-1:0]                 rd_pos;
  logic [KW-1:0]                 k_eff;
  logic [31:0]                   age;
  logic [OW-1:0]                 occ_h;
  logic [AW-1:0]                 head_a;
  logic [KW-1:0]                 seen_inc;
  logic                          emit;

  assign rd_val = rd_data_r[PW +: SAMPLE_BITS];
  assign rd_pos = rd_data_r[PW-1:0];
  assign k_eff  = (32'(window_size) > WINDOW_CAPACITY) ? KW'(WINDOW_CAPACITY) : window_size;
  assign age    = (pos_r >= rd_pos) ? 32'(pos_r) - 32'(rd_pos)
                                    : 32'(pos_r) + 2 * WINDOW_CAPACITY - 32'(rd_pos);
  assign head_a = (occ_r == OCC_FULL) ? ptr_inc(head_r) : head_r;

  always_comb begin
    seen_inc = (seen_r < k_r) ? seen_r + KW'(1) : seen_r;
    if (seen_inc > k_r) begin
      seen_inc = k_r;
    end
  end
  assign emit = (k_r != '0) && (seen_inc >= k_r);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    k_nxt     = k_r;
    smp_nxt   = smp_r;
    last_nxt  = last_r;
    fwd_nxt   = fwd_r;
    occ_h     = occ_r;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    wr_en     = 1'b0;
    wr_data   = {smp_r, pos_r};
    res.load  = 1'b0;
    res.data.window_max  = fwd_r ? smp_r : rd_val;
    res.data.last_result = last_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          smp_nxt  = in_data.sample;
          last_nxt = in_data.last_sample;
          k_nxt    = k_eff;
          if (occ_r != '0) begin
            rd_en     = 1'b1;
            rd_addr   = head_r;
            state_nxt = S_HEAD;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end
      S_HEAD: begin
        // stale head leaves once its age reaches the window length
        if (age >= 32'(k_r)) begin
          head_nxt = ptr_inc(head_r);
          occ_h    = occ_r - OW'(1);
        end
        occ_nxt = occ_h;
        if (occ_h != '0) begin
          rd_en     = 1'b1;
          rd_addr   = ptr_dec(tail_r);
          state_nxt = S_POP;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_POP: begin
        if (rd_val < smp_r) begin
          tail_nxt = ptr_dec(tail_r);
          occ_nxt  = occ_r - OW'(1);
          if (occ_r != OW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec(ptr_dec(tail_r));
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        wr_en     = 1'b1;
        head_nxt  = head_a;
        occ_nxt   = (occ_r == OCC_FULL) ? occ_r : occ_r + OW'(1);
        tail_nxt  = ptr_inc(tail_r);
        pos_nxt   = (pos_r == POS_LAST) ? '0 : pos_r + PW'(1);
        rd_en     = 1'b1;
        rd_addr   = head_a;
        // new head is the entry being written this cycle
        fwd_nxt   = (head_a == tail_r);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!(emit && blocked)) begin
          res.load  = emit;
          seen_nxt  = seen_inc;
          state_nxt = S_IDLE;
          if (last_r) begin
            head_nxt = '0;
            tail_nxt = '0;
            occ_nxt  = '0;
            pos_nxt  = '0;
            seen_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      pos_r   <= '0;
      seen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    smp_r  <= smp_nxt;
    last_r <= last_nxt;
    fwd_r  <= fwd_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_FULL) else $error("deque occupancy beyond capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == '0 |-> head_r == tail_r) else $error("empty deque with split pointers");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> state_r == S_EMIT && !blocked) else $error("result loaded into busy register");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE) else $error("accepted sample not processed");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |=> state_r == S_IDLE) else $error("sequencer not idle after result");

endmodule

// ===== sv/sliding_window_max_core.sv =====
// steps: from accept, an empty deque goes to the append and result steps; otherwise
//   the stale head check and the tail pops (none when it runs empty) come first
// throughput: one sample in flight, set by the single deque memory read port walking
//   head and tail entries; the next is taken in idle once the result step is done
// reset: synchronous active-low rst_n empties the deque and sets window_size to 1;
//   entry memory contents are not cleared and no clearing pass is needed
module sliding_window_max_core #(
  parameter int unsigned WINDOW_CAPACITY = swm_pkg::DEF_WINDOW_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [swm_pkg::WIN_CFG_BITS-1:0] cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  swm_pkg::swm_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output swm_pkg::swm_out_t                out_data
);
  import swm_pkg::*;

  // window length register: user writes only while no sample is in flight; not enforced
  logic [WIN_CFG_BITS-1:0] window_size_r;
  logic [WIN_CFG_BITS-1:0] window_size_nxt;

  // result hand-off between sequencer and output register
  swm_res_t res;
  logic     blocked;

  assign window_size_nxt = cfg_wr_en ? cfg_wr_data : window_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RESET;
    end else begin
      window_size_r <= window_size_nxt;
    end
  end

  // per-sample steps: stale head check, tail pops, append, result
  swm_seq #(
    .WINDOW_CAPACITY (WINDOW_CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .window_size (window_size_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .blocked     (blocked),
    .res         (res)
  );

  // output register parts the result side from the sample side, so a new
  // sample transfer can start while a result still waits
  swm_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .blocked   (blocked),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== dv/sliding_window_max_core_test.sv =====
// testbench for the sliding window maximum core: predicted maxima checked transfer by transfer
`timescale 1ns / 100ps

module sliding_window_max_core_test;
  import swm_pkg::*;

  localparam int CAP         = DEF_WINDOW_CAPACITY;
  localparam int CYCLE_LIMIT = 400_000;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [WIN_CFG_BITS-1:0] cfg_wr_data;
  logic                    in_valid;
  logic                    in_stall;
  swm_in_t                 in_data;
  logic                    out_valid;
  logic                    out_stall;
  swm_out_t                out_data;

  sliding_window_max_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // predicted state of the deque, kept at the block's own widths
  logic signed [SAMPLE_BITS-1:0] win_vals [0:CAP-1];
  logic [WIN_CFG_BITS-1:0]       win_pos  [0:CAP-1];
  logic [9:0]                    win_head;
  logic [9:0]                    win_tail;
  int                            win_fill;
  logic [WIN_CFG_BITS-1:0]       win_next_pos;
  logic [WIN_CFG_BITS-1:0]       win_seen;
  logic [WIN_CFG_BITS-1:0]       win_len;
  int                            last_pops;

  // maxima still owed by the block, oldest first
  swm_out_t expected_max_q[$];
  swm_out_t want;

  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int items_sent;

  // free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver side: a long hold-off when asked for, otherwise random stall
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker: every output transfer is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_max_q.size() == 0) begin
        error_count++;
        $display("%0t: result max %0d last %0b arrived with none expected",
                 $time, out_data.window_max, out_data.last_result);
      end else begin
        want = expected_max_q.pop_front();
        if (out_data.window_max !== want.window_max) begin
          error_count++;
          $display("%0t: window_max expected %0d got %0d",
                   $time, want.window_max, out_data.window_max);
        end
        if (out_data.last_result !== want.last_result) begin
          error_count++;
          $display("%0t: last_result expected %0b got %0b",
                   $time, want.last_result, out_data.last_result);
        end
      end
    end
  end

  // end of stream and reset both empty the deque and restart the positions
  task automatic clear_window_state();
    win_head     = '0;
    win_tail     = '0;
    win_fill     = 0;
    win_next_pos = '0;
    win_seen     = '0;
  endtask

  // one sample through the deque; queues the maximum when the window is full
  task automatic predict_window_max(input logic signed [SAMPLE_BITS-1:0] value,
                                    input logic last);
    logic [WIN_CFG_BITS-1:0] k;
    logic [WIN_CFG_BITS-1:0] age;
    swm_out_t                res;
    // sizes beyond the store behave as a full-capacity window
    k = (win_len > WIN_CFG_BITS'(CAP)) ? WIN_CFG_BITS'(CAP) : win_len;
    last_pops = 0;
    // at most one stale head entry leaves per sample
    if (win_fill != 0) begin
      age = win_next_pos - win_pos[win_head];
      if (age >= k) begin
        win_head++;
        win_fill--;
      end
    end
    // strictly smaller tail entries go, equal ones stay
    while (win_fill != 0 && win_vals[win_tail - 10'd1] < value) begin
      win_tail--;
      win_fill--;
      last_pops++;
    end
    // no room left: the head makes way
    if (win_fill >= CAP) begin
      win_head++;
      win_fill--;
    end
    win_vals[win_tail] = value;
    win_pos[win_tail]  = win_next_pos;
    win_tail++;
    win_fill++;
    win_next_pos++;
    if (win_seen < k) win_seen++;
    if (win_seen > k) win_seen = k;
    if (k != 0 && win_seen >= k) begin
      res.window_max  = win_vals[win_head];
      res.last_result = last;
      expected_max_q.push_back(res);
    end
    if (last) clear_window_state();
  endtask

  // offer one sample, idling first at random, and return once it is transferred
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{last_sample: last, sample: value};
    do @(posedge clk); while (in_stall);
    predict_window_max(value, last);
    items_sent++;
    // nothing is offered again until the next sample is ready
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // sender pauses until every owed result is in, then lets a silent sample finish
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_max_q.size() != 0) @(posedge clk);
    // a sample with no result still walks the popped tail entries
    repeat (10 + last_pops) @(posedge clk);
  endtask

  // window size is only changed with the block idle
  task automatic set_window(input logic [WIN_CFG_BITS-1:0] size);
    wait_until_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    win_len = size;
  endtask

  // reset value of one: every sample is its own maximum, field extremes included
  task automatic test_default_window();
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b1);
  endtask

  // zero window: deque still moves but nothing comes out
  task automatic test_zero_window();
    set_window('0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sd3, 1'b1);
  endtask

  // stream ending before the window fills gives no result, a full one does
  task automatic test_short_stream();
    set_window(11'd4);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd3, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd4, 1'b1);
  endtask

  // equal samples stay queued and age out one by one
  task automatic test_equal_samples();
    set_window(11'd3);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd4, 1'b0);
    send_sample(-16'sd1, 1'b1);
  endtask

  // shrinking mid-stream leaves stale entries that drain one per sample
  task automatic test_resize_midstream();
    set_window(11'd5);
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd8, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd6, 1'b0);
    send_sample(16'sd5, 1'b0);
    set_window(11'd2);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  // receiver holds off while samples keep coming, so the input side backs up
  task automatic test_backpressure();
    set_window(11'd2);
    hold_off_cycles = 300;
    for (int i = 0; i < 40; i++)
      send_sample(SAMPLE_BITS'($urandom), i == 39);
    wait_until_idle();
  endtask

  // random streams, mostly small windows, with varied sample shapes
  task automatic test_random_streams(input int item_count);
    int                            target;
    int                            len;
    int                            mode;
    int                            r;
    logic signed [SAMPLE_BITS-1:0] value;
    target = items_sent + item_count;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 35) begin
        r = $urandom_range(99);
        if (r < 6)       set_window('0);
        else if (r < 76) set_window(WIN_CFG_BITS'($urandom_range(1, 8)));
        else if (r < 92) set_window(WIN_CFG_BITS'($urandom_range(9, 40)));
        else             set_window(WIN_CFG_BITS'($urandom_range(41, 2047)));
      end else if (r < 42) begin
        wait_until_idle();
      end
      len   = $urandom_range(1, 40);
      mode  = $urandom_range(3);
      value = SAMPLE_BITS'($urandom);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: value = SAMPLE_BITS'($urandom);
          // narrow range gives plenty of equal samples
          1: value = SAMPLE_BITS'($urandom_range(0, 4)) - 16'sd2;
          // slow descent builds a deep deque
          2: value = value - SAMPLE_BITS'($urandom_range(0, 3));
          default: begin
            case ($urandom_range(3))
              0: value = 16'sh7FFF;
              1: value = 16'sh8000;
              2: value = 16'sh0000;
              default: value = 16'shFFFF;
            endcase
          end
        endcase
        // occasional resize with the stream still open
        if (i == len / 2 && $urandom_range(99) < 10)
          set_window(WIN_CFG_BITS'($urandom_range(1, 12)));
        send_sample(value, i == len - 1);
      end
    end
  endtask

  // wide window: deep deque, whole-deque pops, then an oversize setting
  // on a stream too short to fill it
  task automatic test_deep_window();
    logic signed [SAMPLE_BITS-1:0] value;
    set_window(11'd200);
    value = 16'sd30000;
    for (int i = 0; i < 240; i++) begin
      if (i == 150 || i == 230) value = 16'sh7FFF;
      else value = value - SAMPLE_BITS'($urandom_range(0, 40));
      send_sample(value, i == 239);
    end
    set_window(11'h7FF);
    for (int i = 0; i < 10; i++)
      send_sample(SAMPLE_BITS'($urandom), i == 9);
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_stall       = 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    hold_off_cycles = 0;
    items_sent      = 0;
    last_pops       = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    win_len         = WINDOW_SIZE_RESET;
    clear_window_state();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // sender rarely idles, receiver mostly stalls
    send_idle_pct  = 11;
    recv_stall_pct = 77;
    test_default_window();
    test_zero_window();
    test_short_stream();
    test_equal_samples();
    test_resize_midstream();
    test_random_streams(100);

    // sender mostly idles, receiver rarely stalls
    send_idle_pct  = 77;
    recv_stall_pct = 11;
    test_backpressure();
    test_random_streams(100);

    // back to back on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_streams(90);
    test_deep_window();

    wait_until_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
